>>> src/assert_macros.svh
// Assertion macros shared by the quaternion to Euler angle blocks.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> src/qte_pkg.sv
// Package for the quaternion to Euler angle converter: widths, constants,
// the arctangent table and the job record passed from front to back end.
package qte_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int QW      = 16;  // quaternion component width
  localparam int PW      = 32;  // product width
  localparam int FW      = 34;  // quadratic form width
  localparam int SW      = 30;  // clamped asin argument width
  localparam int RW      = 57;  // radicand width
  localparam int SQW     = 58;  // square root working width
  localparam int SQ_STEPS = 29;
  localparam int CW      = 38;  // CORDIC vector width
  localparam int ZW      = 28;  // CORDIC angle width, Q.24
  localparam int AW      = 16;
  localparam int YW      = 15;
  localparam int RND_SH  = 11;
  localparam int RZW     = ZW - RND_SH;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);
  localparam int ATAN_N  = 24;

  localparam longint ONE_Q28      = 268435456;
  localparam longint PI_Q24       = 52707179;
  localparam longint ANG_MAX_FULL = 25736;
  localparam longint ANG_MAX_HALF = 12868;
  localparam longint RND_HALF     = 1024;

  localparam logic signed [ZW-1:0] ATAN_TAB [ATAN_N] = '{
    28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331, 28'sd1047214,
    28'sd524117, 28'sd262123, 28'sd131069, 28'sd65536, 28'sd32768,
    28'sd16384, 28'sd8192, 28'sd4096, 28'sd2048, 28'sd1024, 28'sd512,
    28'sd256, 28'sd128, 28'sd64, 28'sd32, 28'sd16, 28'sd8, 28'sd4, 28'sd2
  };

  function automatic logic signed [ZW-1:0] atan_q24(input int idx);
    logic signed [ZW-1:0] a;
    a = (idx < ATAN_N) ? ATAN_TAB[5'(idx)] : '0;
    return a;
  endfunction

  typedef struct packed {
    logic signed [FW-1:0] rn;
    logic signed [FW-1:0] rd;
    logic signed [FW-1:0] pn;
    logic signed [FW-1:0] pd;
    logic signed [SW-1:0] s;
    logic [RW-1:0]        rad;
    logic                 clamped;
  } qte_job_t;

endpackage

>>> src/qte_if.sv
// Handshake channels of the quaternion to Euler angle converter.
// Depends on nothing; payload widths follow the field definitions.
interface qte_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic signed [15:0] quat_w;
  modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

interface qte_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] roll_angle;
  logic signed [15:0] pitch_angle;
  logic signed [14:0] yaw_angle;
  logic               yaw_clamped;
  modport source (output valid, roll_angle, pitch_angle, yaw_angle, yaw_clamped,
                  input ready);
  modport sink (input valid, roll_angle, pitch_angle, yaw_angle, yaw_clamped,
                output ready);
endinterface

>>> src/qte_front.sv
// Front end: products, quadratic forms, asin clamp and radicand.
// Depends on qte_pkg, qte_if and assert_macros.svh.
`include "assert_macros.svh"
module qte_front (
  input  logic              clk,
  input  logic              rst_n,
  qte_in_if.sink            in_ch,
  output logic              job_valid,
  input  logic              job_ready,
  output qte_pkg::qte_job_t job
);

  logic en_f;
  logic v1_r, v2_r, v3_r;
  logic signed [qte_pkg::PW-1:0] p_yw_r, p_xz_r, p_xw_r, p_yz_r, p_xx_r, p_yy_r;
  logic signed [qte_pkg::PW-1:0] p_zz_r, p_xy_r, p_zw_r;
  logic signed [qte_pkg::FW-1:0] rn_r, rd_r, pn_r, pd_r;
  logic signed [qte_pkg::SW-1:0] s_r;
  logic                          cl_r;
  logic signed [qte_pkg::FW-1:0] rn_nxt, rd_nxt, pn_nxt, pd_nxt, s_full;
  logic signed [qte_pkg::SW-1:0] s_nxt;
  logic                          cl_nxt;
  logic signed [qte_pkg::SW-1:0] s_abs;
  logic [qte_pkg::SQ_STEPS-1:0]  s_mag;
  logic [2*qte_pkg::SQ_STEPS-1:0] s_sq;
  logic [qte_pkg::RW-1:0]        rad_nxt;
  qte_pkg::qte_job_t             job_r;

  assign en_f        = !v3_r || job_ready;
  assign in_ch.ready = en_f;
  assign job_valid   = v3_r;
  assign job         = job_r;

  always_comb begin
    rn_nxt = (qte_pkg::FW'(p_yw_r) - qte_pkg::FW'(p_xz_r)) <<< 1;
    pn_nxt = (qte_pkg::FW'(p_xw_r) - qte_pkg::FW'(p_yz_r)) <<< 1;
    rd_nxt = qte_pkg::FW'(qte_pkg::ONE_Q28)
             - ((qte_pkg::FW'(p_yy_r) + qte_pkg::FW'(p_zz_r)) <<< 1);
    pd_nxt = qte_pkg::FW'(qte_pkg::ONE_Q28)
             - ((qte_pkg::FW'(p_xx_r) + qte_pkg::FW'(p_zz_r)) <<< 1);
    s_full = (qte_pkg::FW'(p_xy_r) + qte_pkg::FW'(p_zw_r)) <<< 1;
    priority if (s_full > qte_pkg::FW'(qte_pkg::ONE_Q28)) begin
      s_nxt  = qte_pkg::SW'(qte_pkg::ONE_Q28);
      cl_nxt = 1'b1;
    end else if (s_full < -qte_pkg::FW'(qte_pkg::ONE_Q28)) begin
      s_nxt  = -qte_pkg::SW'(qte_pkg::ONE_Q28);
      cl_nxt = 1'b1;
    end else begin
      s_nxt  = qte_pkg::SW'(s_full);
      cl_nxt = 1'b0;
    end
  end

  always_comb begin
    s_abs   = (s_r < 0) ? -s_r : s_r;
    s_mag   = s_abs[qte_pkg::SQ_STEPS-1:0];
    s_sq    = s_mag * s_mag;
    rad_nxt = (qte_pkg::RW'(1) << (qte_pkg::RW - 1)) - s_sq[qte_pkg::RW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en_f) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_f) begin
      p_yw_r <= in_ch.quat_y * in_ch.quat_w;
      p_xz_r <= in_ch.quat_x * in_ch.quat_z;
      p_xw_r <= in_ch.quat_x * in_ch.quat_w;
      p_yz_r <= in_ch.quat_y * in_ch.quat_z;
      p_xx_r <= in_ch.quat_x * in_ch.quat_x;
      p_yy_r <= in_ch.quat_y * in_ch.quat_y;
      p_zz_r <= in_ch.quat_z * in_ch.quat_z;
      p_xy_r <= in_ch.quat_x * in_ch.quat_y;
      p_zw_r <= in_ch.quat_z * in_ch.quat_w;
      rn_r   <= rn_nxt;
      rd_r   <= rd_nxt;
      pn_r   <= pn_nxt;
      pd_r   <= pd_nxt;
      s_r    <= s_nxt;
      cl_r   <= cl_nxt;
      job_r.rn      <= rn_r;
      job_r.rd      <= rd_r;
      job_r.pn      <= pn_r;
      job_r.pd      <= pd_r;
      job_r.s       <= s_r;
      job_r.rad     <= rad_nxt;
      job_r.clamped <= cl_r;
    end
  end

  `ASSERT_CLK(a_front_hold, (v3_r && !job_ready) |=> v3_r, "front dropped a stalled job")

endmodule

>>> src/qte_fifo.sv
// Short job queue between the front and back ends.
// Depends on qte_pkg and assert_macros.svh.
`include "assert_macros.svh"
module qte_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              push_ready,
  input  qte_pkg::qte_job_t push_job,
  output logic              pop_valid,
  input  logic              pop_ready,
  output qte_pkg::qte_job_t pop_job
);

  qte_pkg::qte_job_t             mem_r [qte_pkg::QDEPTH];
  logic [qte_pkg::QPTR_W-1:0]    wr_r, rd_r;
  logic [qte_pkg::QCNT_W-1:0]    count_r;
  logic                          do_push, do_pop;

  assign push_ready = (count_r != qte_pkg::QCNT_W'(qte_pkg::QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_job    = mem_r[rd_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      if (do_push) wr_r <= wr_r + 1'b1;
      if (do_pop)  rd_r <= rd_r + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= push_job;
  end

  `ASSERT_CLK(a_fifo_bound, count_r <= qte_pkg::QCNT_W'(qte_pkg::QDEPTH), "queue overfilled")
  `ASSERT_CLK(a_fifo_empty, (count_r == '0 && !push) |=> !pop_valid, "empty queue produced a job")

endmodule

>>> src/qte_back.sv
// Back end: pipelined square root, three CORDIC vectoring pipelines,
// rounding, saturation and the output register. Depends on qte_pkg, qte_if and assert_macros.svh.
`include "assert_macros.svh"
module qte_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  output logic              job_ready,
  input  qte_pkg::qte_job_t job,
  qte_out_if.source         out_ch
);

  localparam int NS = qte_pkg::SQ_STEPS;
  localparam int NC = qte_pkg::CORDIC_STAGES;

  logic en, take;
  logic                          sq_v_r   [NS];
  logic [qte_pkg::SQW-1:0]       sq_rem_r [NS];
  logic [qte_pkg::SQW-1:0]       sq_res_r [NS];
  qte_pkg::qte_job_t             sq_job_r [NS];
  logic [qte_pkg::SQW-1:0]       sq_rem_nxt [NS];
  logic [qte_pkg::SQW-1:0]       sq_res_nxt [NS];

  logic                          cv_r  [NC+1];
  logic                          ccl_r [NC+1];
  logic signed [qte_pkg::CW-1:0] cx_r  [3][NC+1];
  logic signed [qte_pkg::CW-1:0] cy_r  [3][NC+1];
  logic signed [qte_pkg::ZW-1:0] cz_r  [3][NC+1];
  logic                          czf_r [3][NC+1];
  logic signed [qte_pkg::CW-1:0] cx_nxt [3][NC+1];
  logic signed [qte_pkg::CW-1:0] cy_nxt [3][NC+1];
  logic signed [qte_pkg::ZW-1:0] cz_nxt [3][NC+1];

  logic signed [qte_pkg::RZW-1:0] ang [3];
  logic signed [qte_pkg::AW-1:0]  roll_r, pitch_r;
  logic signed [qte_pkg::YW-1:0]  yaw_r;
  logic                           clamp_r, vo_r;

  assign en        = !vo_r || out_ch.ready;
  assign take      = en && job_valid;
  assign job_ready = en;

  always_comb begin
    logic [qte_pkg::SQW-1:0] rem, res, bitv, trial;
    for (int k = 0; k < NS; k++) begin
      if (k == 0) begin
        rem = qte_pkg::SQW'(job.rad);
        res = '0;
      end else begin
        rem = sq_rem_r[k-1];
        res = sq_res_r[k-1];
      end
      bitv  = qte_pkg::SQW'(1) << (2 * (NS - 1 - k));
      trial = res + bitv;
      if (rem >= trial) begin
        sq_rem_nxt[k] = rem - trial;
        sq_res_nxt[k] = (res >> 1) + bitv;
      end else begin
        sq_rem_nxt[k] = rem;
        sq_res_nxt[k] = res >> 1;
      end
    end
  end

  always_comb begin
    logic signed [qte_pkg::CW-1:0] x0, y0, xs, ys;
    qte_pkg::qte_job_t jb;
    jb = sq_job_r[NS-1];
    for (int c = 0; c < 3; c++) begin
      unique case (c)
        0: begin
          x0 = qte_pkg::CW'(jb.rd);
          y0 = qte_pkg::CW'(jb.rn);
        end
        1: begin
          x0 = qte_pkg::CW'(jb.pd);
          y0 = qte_pkg::CW'(jb.pn);
        end
        default: begin
          x0 = qte_pkg::CW'({1'b0, sq_res_r[NS-1][NS-1:0]});
          y0 = qte_pkg::CW'(jb.s);
        end
      endcase
      if (x0 < 0) begin
        cx_nxt[c][0] = -x0;
        cy_nxt[c][0] = -y0;
        cz_nxt[c][0] = (y0 >= 0) ? qte_pkg::ZW'(qte_pkg::PI_Q24)
                                 : -qte_pkg::ZW'(qte_pkg::PI_Q24);
      end else begin
        cx_nxt[c][0] = x0;
        cy_nxt[c][0] = y0;
        cz_nxt[c][0] = '0;
      end
      for (int j = 0; j < NC; j++) begin
        xs = cx_r[c][j] >>> j;
        ys = cy_r[c][j] >>> j;
        if (cy_r[c][j] >= 0) begin
          cx_nxt[c][j+1] = cx_r[c][j] + ys;
          cy_nxt[c][j+1] = cy_r[c][j] - xs;
          cz_nxt[c][j+1] = cz_r[c][j] + qte_pkg::atan_q24(j);
        end else begin
          cx_nxt[c][j+1] = cx_r[c][j] - ys;
          cy_nxt[c][j+1] = cy_r[c][j] + xs;
          cz_nxt[c][j+1] = cz_r[c][j] - qte_pkg::atan_q24(j);
        end
      end
    end
  end

  always_comb begin
    logic signed [qte_pkg::ZW-1:0]  zr;
    logic signed [qte_pkg::RZW-1:0] r, lim;
    for (int c = 0; c < 3; c++) begin
      zr  = (cz_r[c][NC] + qte_pkg::ZW'(qte_pkg::RND_HALF)) >>> qte_pkg::RND_SH;
      r   = qte_pkg::RZW'(zr);
      lim = (c == 2) ? qte_pkg::RZW'(qte_pkg::ANG_MAX_HALF)
                     : qte_pkg::RZW'(qte_pkg::ANG_MAX_FULL);
      priority if (czf_r[c][NC]) ang[c] = '0;
      else if (r > lim)          ang[c] = lim;
      else if (r < -lim)         ang[c] = -lim;
      else                       ang[c] = r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NS; k++) sq_v_r[k] <= 1'b0;
      for (int j = 0; j <= NC; j++) cv_r[j] <= 1'b0;
      vo_r <= 1'b0;
    end else if (en) begin
      sq_v_r[0] <= take;
      for (int k = 1; k < NS; k++) sq_v_r[k] <= sq_v_r[k-1];
      cv_r[0] <= sq_v_r[NS-1];
      for (int j = 1; j <= NC; j++) cv_r[j] <= cv_r[j-1];
      vo_r <= cv_r[NC];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_job_r[0] <= job;
      for (int k = 1; k < NS; k++) sq_job_r[k] <= sq_job_r[k-1];
      for (int k = 0; k < NS; k++) begin
        sq_rem_r[k] <= sq_rem_nxt[k];
        sq_res_r[k] <= sq_res_nxt[k];
      end
      ccl_r[0] <= sq_job_r[NS-1].clamped;
      for (int j = 1; j <= NC; j++) ccl_r[j] <= ccl_r[j-1];
      for (int c = 0; c < 3; c++) begin
        czf_r[c][0] <= (cx_nxt[c][0] == '0) && (cy_nxt[c][0] == '0);
        for (int j = 1; j <= NC; j++) czf_r[c][j] <= czf_r[c][j-1];
        for (int j = 0; j <= NC; j++) begin
          cx_r[c][j] <= cx_nxt[c][j];
          cy_r[c][j] <= cy_nxt[c][j];
          cz_r[c][j] <= cz_nxt[c][j];
        end
      end
      roll_r  <= qte_pkg::AW'(ang[0]);
      pitch_r <= qte_pkg::AW'(ang[1]);
      yaw_r   <= qte_pkg::YW'(ang[2]);
      clamp_r <= ccl_r[NC];
    end
  end

  assign out_ch.valid       = vo_r;
  assign out_ch.roll_angle  = roll_r;
  assign out_ch.pitch_angle = pitch_r;
  assign out_ch.yaw_angle   = yaw_r;
  assign out_ch.yaw_clamped = clamp_r;

  `ASSERT_CLK(a_back_take, (en && !job_valid) |=> !sq_v_r[0], "back end took a job from nothing")

endmodule

>>> src/quaternion_to_euler_angles.sv
// Top level of the quaternion to Euler angle converter.
// Depends on qte_pkg, qte_if, qte_front, qte_fifo and qte_back.
//
//   channel  direction  payload
//   in_ch    sink       quat_x, quat_y, quat_z, quat_w (signed Q2.14)
//   out_ch   source     roll_angle, pitch_angle, yaw_angle, yaw_clamped
//
// One quaternion is taken per cycle while the job queue has room; each result
// passes the front-end registers, the job queue, the one-bit-per-stage square
// root, the one-rotation-per-stage CORDIC and the output register.
// Reset clears only the valid bits, queue pointers and fill count. A stalled output
// freezes the back end; the front end runs on until the four-entry queue fills.
module quaternion_to_euler_angles (
  input  logic      clk,
  input  logic      rst_n,
  qte_in_if.sink    in_ch,
  qte_out_if.source out_ch
);

  logic              f_valid, f_ready, b_valid, b_ready;
  qte_pkg::qte_job_t f_job, b_job;

  qte_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .job_valid (f_valid),
    .job_ready (f_ready),
    .job       (f_job)
  );

  qte_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (f_valid),
    .push_ready (f_ready),
    .push_job   (f_job),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_job    (b_job)
  );

  qte_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (b_valid),
    .job_ready (b_ready),
    .job       (b_job),
    .out_ch    (out_ch)
  );

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for quaternion_to_euler_angles: directed, drain and random tests.
// Depends on qte_pkg and the qte_in_if / qte_out_if interfaces; a built-in
// fixed-point CORDIC predictor checks every result transfer.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [14:0] yaw;
    logic               clamp;
  } euler_t;

  localparam longint ATAN_Q24 [24] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };
  localparam int IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  qte_in_if  in_ch ();
  qte_out_if out_ch ();

  quaternion_to_euler_angles u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always #5 clk = ~clk;

  euler_t angle_q [$];
  int     mismatches = 0;
  int     n_sent = 0;
  int     n_checked = 0;
  int     n_clamped = 0;
  int     idle_cycles = 0;
  bit     rdy_stall_en = 1'b1;

  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned res;
    longint unsigned bt;
    res = 0;
    bt = 64'd1 << 56;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  function automatic longint cordic_angle(input longint num, input longint den,
                                          input longint lim);
    longint vx, vy, ang, xs, ys, a, r;
    vx = den;
    vy = num;
    ang = 0;
    if (vx == 0 && vy == 0) return 0;
    if (vx < 0) begin
      ang = (vy >= 0) ? qte_pkg::PI_Q24 : -qte_pkg::PI_Q24;
      vx = -vx;
      vy = -vy;
    end
    for (int i = 0; i < qte_pkg::CORDIC_STAGES; i++) begin
      xs = vx >>> i;
      ys = vy >>> i;
      a = (i < 24) ? ATAN_Q24[i] : 0;
      if (vy >= 0) begin
        vx += ys; vy -= xs; ang += a;
      end else begin
        vx -= ys; vy += xs; ang -= a;
      end
    end
    r = (ang + 1024) >>> 11;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic euler_t euler_from_quat(input logic signed [15:0] qx,
      input logic signed [15:0] qy, input logic signed [15:0] qz,
      input logic signed [15:0] qw);
    longint x, y, z, w, rn, rd, pn, pd, s, c;
    longint unsigned s2;
    euler_t e;
    x = qx; y = qy; z = qz; w = qw;
    rn = 2 * (y * w - x * z);
    rd = qte_pkg::ONE_Q28 - 2 * (y * y + z * z);
    pn = 2 * (x * w - y * z);
    pd = qte_pkg::ONE_Q28 - 2 * (x * x + z * z);
    s = 2 * (x * y + z * w);
    e.clamp = 1'b0;
    if (s > qte_pkg::ONE_Q28) begin s = qte_pkg::ONE_Q28; e.clamp = 1'b1; end
    if (s < -qte_pkg::ONE_Q28) begin s = -qte_pkg::ONE_Q28; e.clamp = 1'b1; end
    s2 = (s < 0) ? -s : s;
    s2 = s2 * s2;
    c = root_floor((64'd1 << 56) - s2);
    e.roll = 16'(cordic_angle(rn, rd, qte_pkg::ANG_MAX_FULL));
    e.pitch = 16'(cordic_angle(pn, pd, qte_pkg::ANG_MAX_FULL));
    e.yaw = 15'(cordic_angle(s, c, qte_pkg::ANG_MAX_HALF));
    return e;
  endfunction

  // Transfer monitor, result checker and watchdog.
  always @(posedge clk) begin
    euler_t e;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        angle_q.push_back(euler_from_quat(in_ch.quat_x, in_ch.quat_y,
                                          in_ch.quat_z, in_ch.quat_w));
      end
      if (out_ch.valid && out_ch.ready) begin
        n_checked++;
        if (out_ch.yaw_clamped) n_clamped++;
        if (angle_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: unexpected result transfer at %0t", $realtime);
        end else begin
          e = angle_q.pop_front();
          if (out_ch.roll_angle !== e.roll || out_ch.pitch_angle !== e.pitch ||
              out_ch.yaw_angle !== e.yaw || out_ch.yaw_clamped !== e.clamp) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: result %0d exp r=%0d p=%0d y=%0d c=%0b got r=%0d p=%0d y=%0d c=%0b",
                       n_checked, e.roll, e.pitch, e.yaw, e.clamp, out_ch.roll_angle,
                       out_ch.pitch_angle, out_ch.yaw_angle, out_ch.yaw_clamped);
          end
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("ERROR: watchdog expired with %0d results outstanding", angle_q.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Result-side back-pressure: mostly short stalls, now and then a long one.
  initial begin
    int len;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
      @(negedge clk);
      out_ch.ready <= 1'b1;
      repeat (len - 1) @(negedge clk);
      if (rdy_stall_en && $urandom_range(0, 2) == 0) begin
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        @(negedge clk);
        out_ch.ready <= 1'b0;
        repeat (len - 1) @(negedge clk);
      end
    end
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 3) != 0) return 0;
    if ($urandom_range(0, 12) == 0) return $urandom_range(8, 30);
    return $urandom_range(1, 3);
  endfunction

  task automatic send_quat(input logic signed [15:0] qx, input logic signed [15:0] qy,
                           input logic signed [15:0] qz, input logic signed [15:0] qw,
                           input int gap);
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.quat_x <= qx;
    in_ch.quat_y <= qy;
    in_ch.quat_z <= qz;
    in_ch.quat_w <= qw;
    forever begin
      #1;
      if (in_ch.ready) begin
        @(posedge clk);
        break;
      end
      @(negedge clk);
    end
    n_sent++;
  endtask

  task automatic idle_until_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait (angle_q.size() == 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic test_directed();
    send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd16384, 0);
    send_quat(16'sd16384, 16'sd0, 16'sd0, 16'sd0, 0);
    send_quat(16'sd0, 16'sd16384, 16'sd0, 16'sd0, 0);
    send_quat(16'sd0, 16'sd0, 16'sd16384, 16'sd0, 0);
    send_quat(-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384, 0);
    send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd0, 0);
    // Roll with both arguments zero.
    send_quat(16'sd0, 16'sd8192, 16'sd8192, 16'sd0, 0);
    // Gimbal lock, just below, exactly at and beyond the asin limits.
    send_quat(16'sd11585, 16'sd11585, 16'sd0, 16'sd0, 0);
    send_quat(16'sd16384, 16'sd16384, 16'sd0, 16'sd0, 1);
    send_quat(-16'sd16384, 16'sd16384, 16'sd0, 16'sd0, 0);
    send_quat(16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192, 0);
    send_quat(16'sd8192, -16'sd8192, 16'sd8192, -16'sd8192, 0);
    // Negative denominators with positive and negative numerators.
    send_quat(16'sd0, 16'sd12000, 16'sd4000, 16'sd9000, 0);
    send_quat(16'sd0, 16'sd12000, 16'sd4000, -16'sd9000, 2);
    send_quat(16'sd13000, 16'sd2000, 16'sd3000, -16'sd9000, 0);
    send_quat(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 0);
    send_quat(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 0);
    send_quat(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, 0);
    send_quat(16'sd1, -16'sd1, 16'sd1, 16'sd16383, 0);
    send_quat(16'sd5, 16'sd0, -16'sd16384, 16'sd0, 0);
    send_quat(-16'sd11585, 16'sd0, 16'sd0, 16'sd11585, 0);
  endtask

  task automatic test_drain_pause();
    for (int i = 0; i < 12; i++)
      send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 0);
    idle_until_drained();
  endtask

  task automatic test_random(input int count);
    real rx, ry, rz, rw, nrm;
    logic signed [15:0] q [4];
    int sel;
    for (int i = 0; i < count; i++) begin
      if (i % 200 == 0) rdy_stall_en = (i % 400 == 0);
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
        rx = real'($urandom_range(0, 2000)) - 1000.0;
        ry = real'($urandom_range(0, 2000)) - 1000.0;
        rz = real'($urandom_range(0, 2000)) - 1000.0;
        rw = real'($urandom_range(0, 2000)) - 1000.0;
        if ($urandom_range(0, 4) == 0) begin
          rz = rx; rw = ry;   // pushes 2xy + 2zw towards the asin limit
        end
        nrm = $sqrt(rx * rx + ry * ry + rz * rz + rw * rw);
        if (nrm < 1.0) begin rw = 1.0; nrm = 1.0; end
        q[0] = 16'($rtoi(rx * 16384.0 / nrm));
        q[1] = 16'($rtoi(ry * 16384.0 / nrm));
        q[2] = 16'($rtoi(rz * 16384.0 / nrm));
        q[3] = 16'($rtoi(rw * 16384.0 / nrm));
      end else if (sel < 85) begin
        foreach (q[k]) q[k] = 16'($urandom_range(0, 32768)) - 16'sd16384;
      end else begin
        foreach (q[k]) q[k] = 16'($urandom);
      end
      send_quat(q[0], q[1], q[2], q[3], pick_gap());
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.quat_x = '0;
    in_ch.quat_y = '0;
    in_ch.quat_z = '0;
    in_ch.quat_w = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_drain_pause();
    test_random(1020);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait (angle_q.size() == 0);
    repeat (100) @(posedge clk);
    $display("Covered %0d quaternions and %0d checked results, %0d with a clamped asin.",
             n_sent, n_checked, n_clamped);
    if (mismatches == 0 && angle_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
